FILE: rtl/tdm_pkg.sv
// Shared types and constants for the tank drive mixer with link failsafe.
`default_nettype none
package tdm_pkg;

  localparam int THR_W   = 10;
  localparam int LEVEL_W = 8;
  localparam int TICK_W  = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_OFF_BELOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_ON_ABOVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_HOLD_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_FLOOR     = 3'd4;

  // Register reset values
  localparam logic [THR_W-1:0]   LIGHT_OFF_RST  = 10'd515;
  localparam logic [THR_W-1:0]   LIGHT_ON_RST   = 10'd970;
  localparam logic [TICK_W-1:0]  LINK_HOLD_RST  = 8'd60;
  localparam logic [TICK_W-1:0]  BLINK_RST      = 8'd50;
  localparam logic [LEVEL_W-1:0] DRIVE_FLOOR_RST = 8'd192;

  // Mixer constants
  localparam logic [THR_W-1:0] STICK_CENTER  = 10'd512;
  localparam logic [5:0]       DRIVE_MIN     = 6'd2;
  localparam logic [7:0]       STEER_DEAD    = 8'd2;
  localparam logic [8:0]       SCALE_FULL    = 9'd256;
  localparam logic [6:0]       SCALE_PERCENT = 7'd100;
  // floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for p < 2^15
  localparam logic [15:0]      RECIP_100     = 16'd41944;
  localparam int               RECIP_SHIFT   = 22;

  typedef struct packed {
    logic             packet_valid;
    logic [THR_W-1:0] throttle;
    logic [THR_W-1:0] steering;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_first;
    logic [LEVEL_W-1:0] pwm_second;
    logic               backlight_on;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic divide;
    logic commit;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/tank_drive_mixer_failsafe.sv
// Top level: tank drive mixer with radio link failsafe.
// Steps: mix at input accept, then scale, divide and commit; the output word is registered at commit.
// A new word is taken only in the idle state, after the sequencer has walked the level
//   multiply and reciprocal divide by 100 and committed; a stalled output holds commit.
// Reset (rst, synchronous, active high): registers to their defaults, light off,
//   hold counter 0, blink counter 50, both levels 0, no output word pending.
`default_nettype none
module tank_drive_mixer_failsafe (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write port
  input  wire logic                          cfg_we,
  input  wire logic [tdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tdm_pkg::CFG_W-1:0]     cfg_data,
  // input words, one per control tick
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire tdm_pkg::in_word_t             in_data,
  // output words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tdm_pkg::out_word_t                 out_data
);

  tdm_pkg::cmd_t cmd;

  // Sequencer: idle -> scale -> divide -> commit. The output word sits in its
  // own register, so a new word is taken while the previous one waits.
  tdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: the mix is taken at accept, then level * factor, then /100 by
  // reciprocal multiply; commit applies packet, hold counter and blink logic.
  // pwm_first carries the right side, pwm_second the left side.
  tdm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/tdm_ctrl.sv
// Sequencer for the mixer datapath and the output word handshake.
`default_nettype none
module tdm_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tdm_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCALE  = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scale, cmd.divide, cmd.commit}))
    else $error("more than one datapath command");
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise out_valid");
  a_load_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.scale ##1 cmd.divide ##1 (state == ST_COMMIT))
    else $error("sequence broke after load");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit over a pending word");
`endif

endmodule
`default_nettype wire

FILE: rtl/tdm_datapath.sv
// Mixer arithmetic, failsafe counters, config registers and output register.
`default_nettype none
module tdm_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tdm_pkg::CFG_W-1:0]     cfg_data,
  input  wire tdm_pkg::in_word_t             in_data,
  input  wire tdm_pkg::cmd_t                 cmd,
  output tdm_pkg::out_word_t                 out_data
);

  // config
  logic [tdm_pkg::THR_W-1:0]   light_off_below;
  logic [tdm_pkg::THR_W-1:0]   light_on_above;
  logic [tdm_pkg::TICK_W-1:0]  link_hold_ticks;
  logic [tdm_pkg::TICK_W-1:0]  blink_ticks;
  logic [tdm_pkg::LEVEL_W-1:0] drive_floor;

  // block state
  logic                        light_state;
  logic [tdm_pkg::TICK_W-1:0]  link_counter;
  logic [tdm_pkg::TICK_W-1:0]  blink_counter;
  logic [tdm_pkg::LEVEL_W-1:0] level_first;
  logic [tdm_pkg::LEVEL_W-1:0] level_second;

  // per-word pipeline registers
  logic                        pkt;
  logic [tdm_pkg::THR_W-1:0]   thr;
  logic [tdm_pkg::LEVEL_W-1:0] base;
  logic [6:0]                  factor;
  logic                        scale_en;
  logic                        steer_right;
  logic [14:0]                 prod;
  logic [tdm_pkg::LEVEL_W-1:0] scaled;

  // mix stage, straight from the input word
  logic [5:0]  drive;
  logic [8:0]  drive_sum;
  logic [7:0]  base_next;
  logic [7:0]  mag;
  logic [8:0]  keep;
  logic [15:0] keep_pct;
  logic [9:0]  ste_low;

  always_comb begin
    if (in_data.throttle > tdm_pkg::STICK_CENTER) begin
      drive = 6'((in_data.throttle - tdm_pkg::STICK_CENTER) >> 3);
    end else begin
      drive = '0;
    end
    drive_sum = {3'b0, drive} + {1'b0, drive_floor};
    if (drive <= tdm_pkg::DRIVE_MIN) begin
      base_next = '0;
    end else if (drive_sum[8]) begin
      base_next = '1;
    end else begin
      base_next = drive_sum[7:0];
    end
    ste_low = tdm_pkg::STICK_CENTER - in_data.steering;
    if (in_data.steering >= tdm_pkg::STICK_CENTER) begin
      mag = {1'b0, 7'(in_data.steering[8:0] >> 2)};
    end else begin
      mag = 8'(ste_low >> 2);
    end
    keep     = tdm_pkg::SCALE_FULL - {1'b0, mag};
    keep_pct = {7'b0, keep} * {9'b0, tdm_pkg::SCALE_PERCENT};
  end

  // scale and divide stages
  logic [30:0] recip_prod;
  assign recip_prod = {16'b0, prod} * {15'b0, tdm_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pkt         <= in_data.packet_valid;
      thr         <= in_data.throttle;
      base        <= base_next;
      factor      <= keep_pct[14:8];
      scale_en    <= (mag > tdm_pkg::STEER_DEAD);
      steer_right <= (in_data.steering >= tdm_pkg::STICK_CENTER);
    end
    if (cmd.scale) begin
      prod <= {7'b0, base} * {8'b0, factor};
    end
    if (cmd.divide) begin
      scaled <= recip_prod[tdm_pkg::RECIP_SHIFT +: tdm_pkg::LEVEL_W];
    end
  end

  // commit: packet update, then failsafe
  logic [7:0] right_lvl;
  logic [7:0] left_lvl;
  logic       light_pkt;
  logic [7:0] link_eff;
  logic [7:0] first_next;
  logic [7:0] second_next;
  logic [7:0] link_next;
  logic [7:0] blink_next;
  logic       light_next;

  always_comb begin
    right_lvl = (scale_en && !steer_right) ? scaled : base;
    left_lvl  = (scale_en && steer_right) ? scaled : base;
    light_pkt = light_state;
    if (thr < light_off_below) begin
      light_pkt = 1'b0;
    end else if (thr > light_on_above) begin
      light_pkt = 1'b1;
    end
    if (pkt) begin
      link_eff    = link_hold_ticks;
      first_next  = right_lvl;
      second_next = left_lvl;
      light_next  = light_pkt;
    end else begin
      link_eff    = link_counter;
      first_next  = level_first;
      second_next = level_second;
      light_next  = light_state;
    end
    blink_next = blink_counter;
    link_next  = link_eff;
    if (link_eff != '0) begin
      link_next = link_eff - 8'd1;
    end else begin
      first_next  = '0;
      second_next = '0;
      if (blink_counter != '0) begin
        blink_next = blink_counter - 8'd1;
      end else begin
        blink_next = blink_ticks;
        light_next = !light_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_off_below <= tdm_pkg::LIGHT_OFF_RST;
      light_on_above  <= tdm_pkg::LIGHT_ON_RST;
      link_hold_ticks <= tdm_pkg::LINK_HOLD_RST;
      blink_ticks     <= tdm_pkg::BLINK_RST;
      drive_floor     <= tdm_pkg::DRIVE_FLOOR_RST;
      light_state     <= 1'b0;
      link_counter    <= '0;
      blink_counter   <= tdm_pkg::BLINK_RST;
      level_first     <= '0;
      level_second    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tdm_pkg::CFG_LIGHT_OFF_BELOW: light_off_below <= cfg_data;
          tdm_pkg::CFG_LIGHT_ON_ABOVE:  light_on_above  <= cfg_data;
          tdm_pkg::CFG_LINK_HOLD_TICKS: link_hold_ticks <= cfg_data[7:0];
          tdm_pkg::CFG_BLINK_TICKS:     blink_ticks     <= cfg_data[7:0];
          tdm_pkg::CFG_DRIVE_FLOOR:     drive_floor     <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        light_state   <= light_next;
        link_counter  <= link_next;
        blink_counter <= blink_next;
        level_first   <= first_next;
        level_second  <= second_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.pwm_first    <= first_next;
      out_data.pwm_second   <= second_next;
      out_data.backlight_on <= light_next;
    end
  end

`ifndef SYNTHESIS
  a_failsafe_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && link_eff == '0) |=> (level_first == '0 && level_second == '0))
    else $error("failsafe left a level nonzero");
  a_reload: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && pkt && link_hold_ticks != '0) |=>
      (link_counter == $past(link_hold_ticks) - 8'd1))
    else $error("hold counter not reloaded by packet");
  a_out_matches: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (out_data.pwm_first == level_first &&
                    out_data.pwm_second == level_second &&
                    out_data.backlight_on == light_state))
    else $error("output word differs from state");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_tank_drive_mixer_failsafe.sv
// Self-checking testbench for the tank drive mixer: predicted output words vs. observed.
module tb_tank_drive_mixer_failsafe;
  import tdm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 128;
  localparam int LEVEL_MAX      = (1 << LEVEL_W) - 1;
  localparam int MAX_DROPOUT    = 40;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LIGHT_OFF_BELOW;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;

  tank_drive_mixer_failsafe uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Mixer prediction: register copies and tick state, updated per accepted word
  logic [THR_W-1:0]   off_below_m, on_above_m;
  logic [TICK_W-1:0]  hold_ticks_m, blink_ticks_m;
  logic [LEVEL_W-1:0] floor_m;
  logic               light_m;
  logic [TICK_W-1:0]  link_cnt_m, blink_cnt_m;
  logic [LEVEL_W-1:0] right_m, left_m;

  out_word_t expected_words[$];

  int errors;
  int words_sent;
  int words_checked;
  int failsafe_ticks;
  int settings_applied;
  int quiet_cycles;
  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // One control tick of the mixer: packet handling, then hold / failsafe update.
  task automatic mix_tick(input in_word_t w, output out_word_t r);
    int thr, ste, drive, left, right, mag, factor;
    thr = w.throttle;
    ste = w.steering;
    if (w.packet_valid) begin
      link_cnt_m = hold_ticks_m;
      // off test first, so crossed thresholds favor off
      if (w.throttle < off_below_m) light_m = 1'b0;
      else if (w.throttle > on_above_m) light_m = 1'b1;
      drive = (thr > int'(STICK_CENTER)) ? (thr - int'(STICK_CENTER)) / 8 : 0;
      if (drive > int'(DRIVE_MIN)) begin
        drive = drive + int'(floor_m);
        if (drive > LEVEL_MAX) drive = LEVEL_MAX;  // floor above 192 can overflow
      end else begin
        drive = 0;
      end
      left  = drive;
      right = drive;
      // steering magnitude, truncated toward zero
      mag = (ste >= int'(STICK_CENTER)) ? (ste - int'(STICK_CENTER)) / 4
                                        : (int'(STICK_CENTER) - ste) / 4;
      if (mag > int'(STEER_DEAD)) begin
        factor = ((int'(SCALE_FULL) - mag) * int'(SCALE_PERCENT)) / int'(SCALE_FULL);
        if (ste >= int'(STICK_CENTER)) left = (left * factor) / int'(SCALE_PERCENT);
        else right = (right * factor) / int'(SCALE_PERCENT);
      end
      right_m = LEVEL_W'(right);
      left_m  = LEVEL_W'(left);
    end
    if (link_cnt_m != 0) begin
      link_cnt_m = link_cnt_m - 1'b1;
    end else begin
      // link lost (or zero hold): motors off, backlight blinks
      failsafe_ticks++;
      right_m = '0;
      left_m  = '0;
      if (blink_cnt_m != 0) begin
        blink_cnt_m = blink_cnt_m - 1'b1;
      end else begin
        blink_cnt_m = blink_ticks_m;
        light_m     = ~light_m;
      end
    end
    r.pwm_first    = right_m;
    r.pwm_second   = left_m;
    r.backlight_on = light_m;
  endtask

  // Scoreboard: check each accepted output word, then predict for each accepted input word.
  always @(posedge clk) begin : track_words
    out_word_t want;
    if (rst) begin
      off_below_m   = LIGHT_OFF_RST;
      on_above_m    = LIGHT_ON_RST;
      hold_ticks_m  = LINK_HOLD_RST;
      blink_ticks_m = BLINK_RST;
      floor_m       = DRIVE_FLOOR_RST;
      light_m       = 1'b0;
      link_cnt_m    = '0;
      blink_cnt_m   = BLINK_RST;
      right_m       = '0;
      left_m        = '0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: output word with nothing expected, actual %h", $time, out_data);
          errors++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (out_data.pwm_first !== want.pwm_first) begin
            $display("%0t: pwm_first mismatch, expected %0d, actual %0d",
                     $time, want.pwm_first, out_data.pwm_first);
            errors++;
          end
          if (out_data.pwm_second !== want.pwm_second) begin
            $display("%0t: pwm_second mismatch, expected %0d, actual %0d",
                     $time, want.pwm_second, out_data.pwm_second);
            errors++;
          end
          if (out_data.backlight_on !== want.backlight_on) begin
            $display("%0t: backlight_on mismatch, expected %0d, actual %0d",
                     $time, want.backlight_on, out_data.backlight_on);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        mix_tick(in_data, want);
        expected_words.push_back(want);
      end
    end
  end

  // Watchdog: ends the run when neither side completes a handshake for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no handshake for %0d cycles, %0d words pending",
               $time, quiet_cycles, expected_words.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: random stall before taking each word
  initial begin : output_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = out_idle_en ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Sends one word after a random gap; valid stays high across back-to-back words.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_fields(input logic pv, input logic [THR_W-1:0] thr,
                             input logic [THR_W-1:0] ste);
    in_word_t w;
    w.packet_valid = pv;
    w.throttle     = thr;
    w.steering     = ste;
    send_word(w);
  endtask

  // Drops valid and waits until every predicted word has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_LIGHT_OFF_BELOW: off_below_m   = data;
      CFG_LIGHT_ON_ABOVE:  on_above_m    = data;
      CFG_LINK_HOLD_TICKS: hold_ticks_m  = data[TICK_W-1:0];
      CFG_BLINK_TICKS:     blink_ticks_m = data[TICK_W-1:0];
      CFG_DRIVE_FLOOR:     floor_m       = data[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all five registers while idle, plus one write to an unused index.
  task automatic apply_settings(input logic [CFG_W-1:0] off_v, on_v, hold_v, blink_v,
                                floor_v);
    wait_idle();
    write_reg(CFG_LIGHT_OFF_BELOW, off_v);
    write_reg(CFG_LIGHT_ON_ABOVE, on_v);
    write_reg(CFG_LINK_HOLD_TICKS, hold_v);
    write_reg(CFG_BLINK_TICKS, blink_v);
    write_reg(CFG_DRIVE_FLOOR, floor_v);
    // unused index must be ignored
    write_reg(CFG_IDX_W'(CFG_DRIVE_FLOOR + $urandom_range(1, 3)), CFG_W'($urandom()));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Reset settings: thresholds, drive dead band and steering dead band edges.
  task automatic test_default_mixing();
    send_fields(1'b0, 10'd1023, 10'd0);    // no packet yet: failsafe blink countdown
    send_fields(1'b1, 10'd1023, 10'd512);  // full drive, light on
    send_fields(1'b1, 10'd536, 10'd512);   // smallest drive past dead band
    send_fields(1'b1, 10'd535, 10'd512);   // drive of 2 stays zero
    send_fields(1'b1, 10'd512, 10'd511);   // centered sticks
    send_fields(1'b1, 10'd0, 10'd0);       // throttle floor, light off
    send_fields(1'b1, 10'd1023, 10'd1023); // hard right: left side cut
    send_fields(1'b1, 10'd1023, 10'd0);    // hard left, widest magnitude: right side cut
    send_fields(1'b1, 10'd800, 10'd523);   // right steer still in dead band
    send_fields(1'b1, 10'd800, 10'd524);   // first scaled step right
    send_fields(1'b1, 10'd800, 10'd501);   // left steer still in dead band
    send_fields(1'b1, 10'd800, 10'd500);   // first scaled step left
    send_fields(1'b1, 10'd514, 10'd512);   // just below off threshold
    send_fields(1'b1, 10'd971, 10'd512);   // just above on threshold
    send_fields(1'b1, 10'd970, 10'd512);   // at on threshold: light held
    send_fields(1'b1, 10'd515, 10'd512);   // at off threshold: light held
    send_fields(1'b0, 10'd0, 10'd1023);    // dropped packet: levels held
  endtask

  // Saturating drive, link loss after a short hold, crossed thresholds, zero hold.
  task automatic test_config_corners();
    apply_settings(LIGHT_OFF_RST, LIGHT_ON_RST, 10'd2, 10'd1, 10'd255);
    send_fields(1'b1, 10'd600, 10'd512);   // drive plus floor saturates
    send_fields(1'b1, 10'd1023, 10'd1023); // saturated, then steered
    send_fields(1'b0, 10'd700, 10'd300);   // hold counting down
    send_fields(1'b0, 10'd700, 10'd300);   // failsafe engages
    send_fields(1'b0, 10'd700, 10'd300);   // still in failsafe: blink counter counts down
    apply_settings(10'd900, 10'd100, 10'd0, 10'd0, CFG_W'(DRIVE_FLOOR_RST));
    send_fields(1'b1, 10'd500, 10'd512);   // crossed thresholds: off test wins
    send_fields(1'b1, 10'd950, 10'd700);   // on branch; zero hold zeroes at once
  endtask

  // Phases of random traffic: packet runs with random sticks, dropouts of random length up to
  // hold plus blink ticks plus 4 words (capped at 40), and a few flipped packet flags as noise.
  task automatic test_random_traffic();
    int p, k, sent_here, run_len, dropout_max, pick;
    bit dropout;
    in_word_t w;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_settings(LIGHT_OFF_RST, LIGHT_ON_RST, CFG_W'(LINK_HOLD_RST),
                          CFG_W'(BLINK_RST), CFG_W'(DRIVE_FLOOR_RST));
        1: apply_settings('0, '0, '0, '0, '0);
        2: apply_settings('1, '1, '1, '1, '1);
        default: apply_settings(CFG_W'($urandom_range(0, 1023)),
                                CFG_W'($urandom_range(0, 1023)),
                                CFG_W'(($urandom_range(0, 3) << TICK_W) | $urandom_range(0, 15)),
                                CFG_W'(($urandom_range(0, 3) << TICK_W) | $urandom_range(0, 7)),
                                CFG_W'(($urandom_range(0, 3) << TICK_W) | $urandom_range(0, 255)));
      endcase
      // stretches without any idling on one or both sides
      in_idle_en  = (p != 1) && (p != 5);
      out_idle_en = (p != 1) && (p != 6);
      dropout_max = int'(hold_ticks_m) + int'(blink_ticks_m) + 4;
      if (dropout_max > MAX_DROPOUT) dropout_max = MAX_DROPOUT;
      sent_here = 0;
      while (sent_here < PHASE_WORDS) begin
        dropout = ($urandom_range(0, 3) == 0);
        run_len = dropout ? $urandom_range(1, dropout_max) : $urandom_range(1, 12);
        for (k = 0; k < run_len && sent_here < PHASE_WORDS; k++) begin
          w.packet_valid = ~dropout;
          if ($urandom_range(0, 15) == 0) w.packet_valid = ~w.packet_valid;
          pick = $urandom_range(0, 5);
          case (pick)
            0, 1, 2: w.throttle = THR_W'($urandom_range(0, 1023));
            3: w.throttle = THR_W'($urandom_range(500, 600));  // drive dead band region
            4: w.throttle = off_below_m + THR_W'($urandom_range(0, 4)) - THR_W'(2);
            default: w.throttle = on_above_m + THR_W'($urandom_range(0, 4)) - THR_W'(2);
          endcase
          if ($urandom_range(0, 9) < 7) w.steering = THR_W'($urandom_range(0, 1023));
          else w.steering = THR_W'($urandom_range(498, 526));  // steering dead band
          send_word(w);
          sent_here++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_mixing();
    test_config_corners();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run: %0d input words sent, %0d output words compared, %0d register settings",
             words_sent, words_checked, settings_applied);
    $display("Run: %0d of the predicted ticks were in failsafe, %0d mismatches",
             failsafe_ticks, errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: tank_drive_mixer_failsafe.f
rtl/tdm_pkg.sv
rtl/tdm_ctrl.sv
rtl/tdm_datapath.sv
rtl/tank_drive_mixer_failsafe.sv
verif/tb_tank_drive_mixer_failsafe.sv
